// ===== src/plcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcs_pkg
// Shared types and constants for the packet link credit sync block.
// ----------------------------------------------------------------------------
package plcs_pkg;

	localparam int MPS_W        = 17;
	localparam int SIZE_W       = 18;
	localparam int MARKER_W     = 64;
	localparam int SPACE_W      = 17;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int COUNT_BITS_DEF   = 20;

	localparam logic [MPS_W-1:0] MPS_RESET = 17'h10000;

	localparam logic [1:0] CMD_SEND_BLK = 2'd0;
	localparam logic [1:0] CMD_SEND_NB  = 2'd1;
	localparam logic [1:0] CMD_RX_HDR   = 2'd2;
	localparam logic [1:0] CMD_BEGIN_RX = 2'd3;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [SIZE_W-1:0]   packet_size;
		logic                rx_loopback;
		logic                rx_sync;
		logic [MARKER_W-1:0] rx_marker;
		logic                rx_wait_mode;
	} item_t;

	typedef struct packed {
		logic                tx_valid;
		logic [SIZE_W-1:0]   tx_size;
		logic                tx_sync;
		logic                tx_loopback;
		logic [MARKER_W-1:0] tx_marker;
		logic                send_accepted;
		logic                call_done;
		logic [SIZE_W-1:0]   returned_size;
		logic [SPACE_W-1:0]  send_space;
	} result_t;

	// loopback marker state
	typedef struct packed {
		logic [MARKER_W-1:0] marker_counter;
		logic [MARKER_W-1:0] waiting_marker;
	} marks_t;

endpackage
`default_nettype wire

// ===== src/packet_link_credit_sync.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted request passes the input register, then the result register,
// to result valid. Throughput: one request per cycle unless result_ready stalls;
// the state update closes in the single logic stage between the two registers.
// Reset: arst_n clears count and markers, sets max packet size to 65536 and
// empties both pipeline stages.
// ----------------------------------------------------------------------------
// packet_link_credit_sync
// Credit flow control for a packet link with loopback marker sync.
// ----------------------------------------------------------------------------
module packet_link_credit_sync
	import plcs_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [MPS_W-1:0] cfg_wdata
);

	item_t                 item_s1;
	logic                  valid_s1;
	result_t               result_s2;
	logic                  valid_s2;
	logic                  adv_s1;
	result_t               res;
	logic [MPS_W-1:0]      mps;
	logic [COUNT_BITS-1:0] count, count_nxt;
	marks_t                marks, marks_nxt;

	// stage 1 moves on whenever the result register is free or being drained
	assign adv_s1     = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			result_s2 <= res;
		end
	end

	plcs_calc #(
		.HEADER_BYTES(HEADER_BYTES),
		.COUNT_BITS  (COUNT_BITS)
	) u_calc (
		.item     (item_s1),
		.mps      (mps),
		.count    (count),
		.marks    (marks),
		.res      (res),
		.count_nxt(count_nxt),
		.marks_nxt(marks_nxt)
	);

	plcs_state #(
		.COUNT_BITS(COUNT_BITS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.upd      (adv_s1),
		.count_nxt(count_nxt),
		.marks_nxt(marks_nxt),
		.mps      (mps),
		.count    (count),
		.marks    (marks)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
`default_nettype wire

// ===== src/plcs_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcs_calc
// Single-pass evaluation of one request against the credit and marker state.
// ----------------------------------------------------------------------------
module plcs_calc
	import plcs_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  item_t                 item,
	input  logic [MPS_W-1:0]      mps,
	input  logic [COUNT_BITS-1:0] count,
	input  marks_t                marks,
	output result_t               res,
	output logic [COUNT_BITS-1:0] count_nxt,
	output marks_t                marks_nxt
);

	localparam int W = ((COUNT_BITS > SIZE_W) ? COUNT_BITS : SIZE_W) + 1;
	localparam logic [W-1:0] CNT_MAX = W'({COUNT_BITS{1'b1}});
	localparam logic [W-1:0] LB_BYTES = W'(HEADER_BYTES + 8);
	localparam logic [W-1:0] HB = W'(HEADER_BYTES);

	logic [W-1:0]        cnt, m, pipe, sz, avail, cnt_dec, gap, add, sum, cnt_fin, av;
	logic                nb_ok, send_go, lb_want, lb_go, marker_hit;
	logic [MARKER_W-1:0] wait_eff, mc_inc;
	logic [SPACE_W-1:0]  space;

	always_comb begin
		cnt   = W'(count);
		m     = W'(mps);
		pipe  = m << 1;
		sz    = W'(item.packet_size);
		avail = (cnt >= pipe) ? '0 : pipe - cnt;
		nb_ok = !(cnt > pipe) && !(sz > avail);

		// sync credit comes back before anything else happens to the count
		if (item.cmd == CMD_RX_HDR && item.rx_sync) begin
			cnt_dec = (cnt > m) ? cnt - m : '0;
		end else begin
			cnt_dec = cnt;
		end

		marker_hit = (item.rx_marker == marks.waiting_marker);
		wait_eff   = (item.cmd == CMD_BEGIN_RX) ? '0 : marks.waiting_marker;
		lb_want    = (item.cmd == CMD_BEGIN_RX) ||
			(item.cmd == CMD_RX_HDR && item.rx_wait_mode && item.rx_loopback && !marker_hit);
		lb_go      = lb_want && (wait_eff == '0) && (m > cnt_dec);
		gap        = m - cnt_dec;
		mc_inc     = marks.marker_counter + 64'd1;
		if (mc_inc == '0) begin
			mc_inc = 64'd1;
		end

		send_go = (item.cmd == CMD_SEND_BLK) || (item.cmd == CMD_SEND_NB && nb_ok);
		add     = send_go ? sz : (lb_go ? LB_BYTES : '0);
		sum     = cnt_dec + add;
		cnt_fin = (sum > CNT_MAX) ? CNT_MAX : sum;

		// space for a non-blocking send after this request
		av = pipe - cnt_fin;
		if (cnt_fin >= pipe) begin
			space = '0;
		end else if (av >= m) begin
			space = mps;
		end else if (av >= HB) begin
			space = av[SPACE_W-1:0];
		end else begin
			space = '0;
		end

		res       = '0;
		marks_nxt = marks;
		case (item.cmd)
			CMD_SEND_BLK, CMD_SEND_NB: begin
				if (send_go) begin
					res.tx_valid      = 1'b1;
					res.tx_size       = item.packet_size;
					res.tx_sync       = (cnt < m && sum >= m) || (cnt < pipe && sum >= pipe);
					res.send_accepted = (item.cmd == CMD_SEND_NB);
				end
			end
			CMD_RX_HDR: begin
				if (!item.rx_loopback) begin
					res.call_done     = 1'b1;
					res.returned_size = item.packet_size;
					if (item.rx_wait_mode) begin
						marks_nxt.waiting_marker = '0;
					end
				end else if (item.rx_wait_mode && marker_hit) begin
					res.call_done            = 1'b1;
					marks_nxt.waiting_marker = '0;
				end
			end
			CMD_BEGIN_RX: begin
				marks_nxt.waiting_marker = '0;
			end
			default: begin
			end
		endcase

		if (lb_go) begin
			res.tx_valid             = 1'b1;
			res.tx_size              = LB_BYTES[SIZE_W-1:0];
			res.tx_sync              = (gap <= LB_BYTES);
			res.tx_loopback          = 1'b1;
			res.tx_marker            = mc_inc;
			marks_nxt.marker_counter = mc_inc;
			marks_nxt.waiting_marker = mc_inc;
		end

		res.send_space = space;
		count_nxt      = cnt_fin[COUNT_BITS-1:0];
	end

endmodule
`default_nettype wire

// ===== src/plcs_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcs_state
// Configuration register, outstanding byte count and loopback marker state.
// ----------------------------------------------------------------------------
module plcs_state
	import plcs_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [MPS_W-1:0]      cfg_wdata,
	input  logic                  upd,
	input  logic [COUNT_BITS-1:0] count_nxt,
	input  marks_t                marks_nxt,
	output logic [MPS_W-1:0]      mps,
	output logic [COUNT_BITS-1:0] count,
	output marks_t                marks
);

	logic [MPS_W-1:0]      mps_q;
	logic [COUNT_BITS-1:0] count_q;
	marks_t                marks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mps_q   <= MPS_RESET;
			count_q <= '0;
			marks_q <= '0;
		end else begin
			if (cfg_we) begin
				mps_q <= cfg_wdata;
			end
			if (upd) begin
				count_q <= count_nxt;
				marks_q <= marks_nxt;
			end
		end
	end

	assign mps   = mps_q;
	assign count = count_q;
	assign marks = marks_q;

endmodule
`default_nettype wire
